/* rtl/eqsd_pkg.sv */
// Shared constants, opcodes and table row type for the event queue dispatcher.
`timescale 1ns / 1ps

package eqsd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF  = 32;
  localparam int unsigned TABLE_DEPTH_DEF  = 16;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned KIND_W      = 8;
  localparam int unsigned HID_W       = 8;
  localparam int unsigned IN_PAY_W    = 32;
  localparam int unsigned OUT_PAY_W   = 32;
  localparam int unsigned PENDING_W   = 6;
  localparam int unsigned S_TDATA_W   = 48;
  localparam int unsigned M_TDATA_W   = 56;
  localparam int unsigned M_TUSER_W   = 2;

  localparam logic [OPCODE_W-1:0] OP_PUBLISH     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PROCESS     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SUBSCRIBE   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_UNSUBSCRIBE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_ENABLE      = 3'd4;

  typedef struct packed {
    logic              en;
    logic [HID_W-1:0]  hid;
    logic [KIND_W-1:0] kind;
  } sub_row_t;

endpackage

/* rtl/event_queue_subscription_dispatcher.sv */
// Top level: event ring queue and subscription table with per-entry dispatch.
// Publish and unknown requests skip the scan and load their result once the output is free.
// Process, subscribe, unsubscribe and enable scan the table one row per cycle, held while a
// delivery waits; process skips the scan on an empty queue, subscribe on a full table.
// One request in flight: the next request is accepted after the final result is loaded.
// Reset clears pointers, counts and control; queue and table RAM contents stay undefined.
`timescale 1ns / 1ps

module event_queue_subscription_dispatcher #(
  parameter int unsigned QUEUE_DEPTH  = eqsd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TABLE_DEPTH  = eqsd_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = eqsd_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // event_kind[7:0], handler_id[15:8], event_payload[47:16]
  input  logic [eqsd_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // opcode[2:0]
  input  logic [eqsd_pkg::OPCODE_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // target_handler[7:0], out_kind[15:8], out_payload[47:16], pending[53:48], zero[55:54]
  output logic [eqsd_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // ok[0], delivered[1]
  output logic [eqsd_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);

  localparam int unsigned QIW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TIW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TCW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EVW = eqsd_pkg::KIND_W + PAYLOAD_BITS;
  localparam int unsigned ROWW = $bits(eqsd_pkg::sub_row_t);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                          state_q, state_d;
  logic [eqsd_pkg::OPCODE_W-1:0] op_q, op_d;
  logic [eqsd_pkg::KIND_W-1:0]   kind_q, kind_d;
  logic [eqsd_pkg::HID_W-1:0]    hid_q, hid_d;
  logic                          ok_q, ok_d;
  logic                          found_q, found_d;
  logic [TCW-1:0]                lim_q, lim_d;
  logic [TCW-1:0]                rd_idx_q, rd_idx_d;
  logic [TIW-1:0]                chk_idx_q, chk_idx_d;
  logic                          data_vld_q, data_vld_d;
  logic                          held_vld_q, held_vld_d;
  logic [eqsd_pkg::HID_W-1:0]    held_hid_q, held_hid_d;

  logic [QIW-1:0] wptr_q, wptr_d;
  logic [QIW-1:0] rptr_q, rptr_d;
  logic [QCW-1:0] count_q, count_d;
  logic [TCW-1:0] sub_count_q, sub_count_d;

  logic                           out_valid_q, out_valid_d;
  logic                           out_ok_q, out_dlv_q, out_last_q;
  logic [eqsd_pkg::HID_W-1:0]     out_tgt_q;
  logic [eqsd_pkg::KIND_W-1:0]    out_kind_q;
  logic [eqsd_pkg::OUT_PAY_W-1:0] out_pay_q;
  logic [eqsd_pkg::PENDING_W-1:0] out_pend_q;

  logic                           out_load;
  logic                           o_ok, o_dlv, o_last;
  logic [eqsd_pkg::HID_W-1:0]     o_tgt;
  logic [eqsd_pkg::KIND_W-1:0]    o_kind;
  logic [eqsd_pkg::OUT_PAY_W-1:0] o_pay;

  logic                          s_fire, out_free, stall;
  logic [eqsd_pkg::KIND_W-1:0]   s_kind;
  logic [eqsd_pkg::HID_W-1:0]    s_hid;
  logic [eqsd_pkg::IN_PAY_W-1:0] s_pay;

  logic           ev_we, ev_re;
  logic [EVW-1:0] ev_wdata, ev_rdata;
  logic [eqsd_pkg::KIND_W-1:0] ev_kind;
  logic [PAYLOAD_BITS-1:0]     ev_pay;

  logic                tb_we, tb_re;
  logic [TIW-1:0]      tb_waddr, tb_raddr;
  eqsd_pkg::sub_row_t  tb_wdata, row;
  logic [ROWW-1:0]     tb_rdata;
  logic                pair_hit, proc_hit;

  assign s_kind = s_axis_tdata_i[7:0];
  assign s_hid  = s_axis_tdata_i[15:8];
  assign s_pay  = s_axis_tdata_i[47:16];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~out_valid_q | m_axis_tready_i;

  assign ev_wdata = {PAYLOAD_BITS'(s_pay), s_kind};
  assign ev_kind  = ev_rdata[eqsd_pkg::KIND_W-1:0];
  assign ev_pay   = ev_rdata[EVW-1:eqsd_pkg::KIND_W];

  assign row      = eqsd_pkg::sub_row_t'(tb_rdata);
  assign pair_hit = (row.kind == kind_q) && (row.hid == hid_q);
  assign proc_hit = (op_q == eqsd_pkg::OP_PROCESS) && ok_q && (row.kind == ev_kind) &&
                    row.en && (row.hid != '0);
  assign stall    = data_vld_q && proc_hit && held_vld_q && !out_free;

  eqsd_ram #(
    .WIDTH (EVW),
    .DEPTH (QUEUE_DEPTH)
  ) u_event_ram (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (wptr_q),
    .wdata_i (ev_wdata),
    .re_i    (ev_re),
    .raddr_i (rptr_q),
    .rdata_o (ev_rdata)
  );

  eqsd_ram #(
    .WIDTH (ROWW),
    .DEPTH (TABLE_DEPTH)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .waddr_i (tb_waddr),
    .wdata_i (tb_wdata),
    .re_i    (tb_re),
    .raddr_i (tb_raddr),
    .rdata_o (tb_rdata)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    kind_d      = kind_q;
    hid_d       = hid_q;
    ok_d        = ok_q;
    found_d     = found_q;
    lim_d       = lim_q;
    rd_idx_d    = rd_idx_q;
    chk_idx_d   = chk_idx_q;
    data_vld_d  = data_vld_q;
    held_vld_d  = held_vld_q;
    held_hid_d  = held_hid_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    count_d     = count_q;
    sub_count_d = sub_count_q;
    ev_we       = 1'b0;
    ev_re       = 1'b0;
    tb_we       = 1'b0;
    tb_waddr    = chk_idx_q;
    tb_wdata    = row;
    tb_re       = 1'b0;
    tb_raddr    = rd_idx_q[TIW-1:0];
    out_load    = 1'b0;
    o_ok        = 1'b1;
    o_dlv       = 1'b1;
    o_tgt       = held_hid_q;
    o_kind      = ev_kind;
    o_pay       = eqsd_pkg::OUT_PAY_W'(ev_pay);
    o_last      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          op_d       = s_axis_tuser_i;
          kind_d     = s_kind;
          hid_d      = s_hid;
          ok_d       = 1'b0;
          found_d    = 1'b0;
          held_vld_d = 1'b0;
          lim_d      = '0;
          unique case (s_axis_tuser_i)
            eqsd_pkg::OP_PUBLISH: begin
              if (count_q < QCW'(QUEUE_DEPTH)) begin
                ev_we   = 1'b1;
                wptr_d  = (wptr_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
                count_d = count_q + 1'b1;
                ok_d    = 1'b1;
              end
            end
            eqsd_pkg::OP_PROCESS: begin
              if (count_q != '0) begin
                ev_re   = 1'b1;
                rptr_d  = (rptr_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
                count_d = count_q - 1'b1;
                ok_d    = 1'b1;
                lim_d   = sub_count_q;
              end
            end
            eqsd_pkg::OP_SUBSCRIBE: begin
              if (sub_count_q < TCW'(TABLE_DEPTH)) begin
                ok_d  = 1'b1;
                lim_d = sub_count_q;
              end
            end
            eqsd_pkg::OP_UNSUBSCRIBE, eqsd_pkg::OP_ENABLE: begin
              lim_d = sub_count_q;
            end
            default: begin
            end
          endcase
          tb_raddr  = '0;
          chk_idx_d = '0;
          if (lim_d != '0) begin
            tb_re      = 1'b1;
            rd_idx_d   = TCW'(1);
            data_vld_d = 1'b1;
          end else begin
            rd_idx_d   = '0;
            data_vld_d = 1'b0;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (data_vld_q) begin
          if (!stall) begin
            unique case (op_q)
              eqsd_pkg::OP_PROCESS: begin
                if (proc_hit) begin
                  out_load   = held_vld_q;
                  held_hid_d = row.hid;
                  held_vld_d = 1'b1;
                end
              end
              eqsd_pkg::OP_SUBSCRIBE: begin
                if (pair_hit && !found_q) begin
                  tb_we       = 1'b1;
                  tb_wdata.en = 1'b1;
                  found_d     = 1'b1;
                end
              end
              eqsd_pkg::OP_UNSUBSCRIBE: begin
                if (pair_hit && !found_q) begin
                  tb_we       = 1'b1;
                  tb_wdata.en = 1'b0;
                  found_d     = 1'b1;
                  ok_d        = 1'b1;
                end
              end
              eqsd_pkg::OP_ENABLE: begin
                if (pair_hit) begin
                  tb_we       = 1'b1;
                  tb_wdata.en = 1'b1;
                  ok_d        = 1'b1;
                end
              end
              default: begin
              end
            endcase
            if (rd_idx_q < lim_q) begin
              tb_re      = 1'b1;
              chk_idx_d  = rd_idx_q[TIW-1:0];
              rd_idx_d   = rd_idx_q + 1'b1;
              data_vld_d = 1'b1;
            end else begin
              data_vld_d = 1'b0;
            end
          end
        end else if (out_free) begin
          out_load = 1'b1;
          o_ok     = ok_q;
          o_last   = 1'b1;
          if ((op_q == eqsd_pkg::OP_PROCESS) && ok_q) begin
            o_dlv = held_vld_q;
            o_tgt = held_vld_q ? held_hid_q : '0;
          end else begin
            o_dlv  = 1'b0;
            o_tgt  = '0;
            o_kind = '0;
            o_pay  = '0;
          end
          if ((op_q == eqsd_pkg::OP_SUBSCRIBE) && ok_q && !found_q) begin
            tb_we       = 1'b1;
            tb_waddr    = sub_count_q[TIW-1:0];
            tb_wdata    = '{en: 1'b1, hid: hid_q, kind: kind_q};
            sub_count_d = sub_count_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ok_q        <= 1'b0;
      found_q     <= 1'b0;
      lim_q       <= '0;
      rd_idx_q    <= '0;
      data_vld_q  <= 1'b0;
      held_vld_q  <= 1'b0;
      wptr_q      <= '0;
      rptr_q      <= '0;
      count_q     <= '0;
      sub_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ok_q        <= ok_d;
      found_q     <= found_d;
      lim_q       <= lim_d;
      rd_idx_q    <= rd_idx_d;
      data_vld_q  <= data_vld_d;
      held_vld_q  <= held_vld_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      count_q     <= count_d;
      sub_count_q <= sub_count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    kind_q     <= kind_d;
    hid_q      <= hid_d;
    chk_idx_q  <= chk_idx_d;
    held_hid_q <= held_hid_d;
    if (out_load) begin
      out_ok_q   <= o_ok;
      out_dlv_q  <= o_dlv;
      out_tgt_q  <= o_tgt;
      out_kind_q <= o_kind;
      out_pay_q  <= o_pay;
      out_last_q <= o_last;
      out_pend_q <= eqsd_pkg::PENDING_W'(count_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_pend_q, out_pay_q, out_kind_q, out_tgt_q};
  assign m_axis_tuser_o  = {out_dlv_q, out_ok_q};
  assign m_axis_tlast_o  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_count_q <= TCW'(TABLE_DEPTH))
    else $error("table count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser_i == eqsd_pkg::OP_PROCESS) && (count_q != '0)
    |=> count_q == $past(count_q) - 1'b1)
    else $error("process did not dequeue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !o_last |-> (op_q == eqsd_pkg::OP_PROCESS) && o_dlv && (o_tgt != '0))
    else $error("non-final result outside a delivery run");

endmodule

/* rtl/eqsd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module eqsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/eqsd_checker.sv */
// Checker for the event queue dispatcher: predicts every result and compares the result stream.
`timescale 1ns / 1ps

module eqsd_checker
  import eqsd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  // event_kind[7:0], handler_id[15:8], event_payload[47:16]
  input  logic [S_TDATA_W-1:0]   s_tdata_i,
  // opcode[2:0]
  input  logic [OPCODE_W-1:0]    s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  // target_handler[7:0], out_kind[15:8], out_payload[47:16], pending[53:48], zero[55:54]
  input  logic [M_TDATA_W-1:0]   m_tdata_i,
  // ok[0], delivered[1]
  input  logic [M_TUSER_W-1:0]   m_tuser_i,
  input  logic                   m_tlast_i,
  output int unsigned            err_count_o,
  output int unsigned            awaiting_o
);

  localparam int unsigned QD = QUEUE_DEPTH_DEF;
  localparam int unsigned TD = TABLE_DEPTH_DEF;

  typedef struct packed {
    logic                 ok;
    logic                 dlv;
    logic [HID_W-1:0]     tgt;
    logic [KIND_W-1:0]    kind;
    logic [OUT_PAY_W-1:0] pay;
    logic                 last;
    logic [PENDING_W-1:0] pend;
  } dispatch_result_t;

  logic [KIND_W-1:0]   ev_kind [QD];
  logic [IN_PAY_W-1:0] ev_pay  [QD];
  int unsigned         rd_idx;
  int unsigned         wr_idx;
  int unsigned         ev_count;

  logic [KIND_W-1:0]   tbl_kind [TD];
  logic [HID_W-1:0]    tbl_hid  [TD];
  logic                tbl_en   [TD];
  int unsigned         tbl_used;

  dispatch_result_t    awaited_results [$];
  int unsigned         errors;

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic apply_request(logic [OPCODE_W-1:0] op, logic [KIND_W-1:0] kind,
                               logic [HID_W-1:0] hid, logic [IN_PAY_W-1:0] pay);
    dispatch_result_t res;
    dispatch_result_t batch [$];
    logic [KIND_W-1:0]   k;
    logic [IN_PAY_W-1:0] p;
    bit                  found;
    res = '0;
    res.last = 1'b1;
    found = 1'b0;
    case (op)
      OP_PUBLISH: begin
        if (ev_count < QD) begin
          ev_kind[wr_idx] = kind;
          ev_pay[wr_idx]  = pay;
          wr_idx = (wr_idx + 1) % QD;
          ev_count++;
          res.ok = 1'b1;
        end
      end
      OP_PROCESS: begin
        if (ev_count != 0) begin
          k = ev_kind[rd_idx];
          p = ev_pay[rd_idx];
          rd_idx = (rd_idx + 1) % QD;
          ev_count--;
          for (int unsigned i = 0; i < tbl_used; i++) begin
            if (tbl_kind[i] == k && tbl_en[i] && tbl_hid[i] != '0) begin
              res.ok   = 1'b1;
              res.dlv  = 1'b1;
              res.tgt  = tbl_hid[i];
              res.kind = k;
              res.pay  = p;
              res.last = 1'b0;
              res.pend = PENDING_W'(ev_count);
              batch.push_back(res);
            end
          end
          if (batch.size() == 0) begin
            res.ok   = 1'b1;
            res.kind = k;
            res.pay  = p;
            res.pend = PENDING_W'(ev_count);
            batch.push_back(res);
          end else begin
            batch[batch.size()-1].last = 1'b1;
          end
        end
      end
      OP_SUBSCRIBE: begin
        if (tbl_used < TD) begin
          res.ok = 1'b1;
          for (int unsigned i = 0; i < tbl_used; i++) begin
            if (!found && tbl_kind[i] == kind && tbl_hid[i] == hid) begin
              tbl_en[i] = 1'b1;
              found = 1'b1;
            end
          end
          if (!found) begin
            tbl_kind[tbl_used] = kind;
            tbl_hid[tbl_used]  = hid;
            tbl_en[tbl_used]   = 1'b1;
            tbl_used++;
          end
        end
      end
      OP_UNSUBSCRIBE: begin
        for (int unsigned i = 0; i < tbl_used; i++) begin
          if (!found && tbl_kind[i] == kind && tbl_hid[i] == hid) begin
            tbl_en[i] = 1'b0;
            found = 1'b1;
          end
        end
        res.ok = found;
      end
      OP_ENABLE: begin
        for (int unsigned i = 0; i < tbl_used; i++) begin
          if (tbl_kind[i] == kind && tbl_hid[i] == hid) begin
            tbl_en[i] = 1'b1;
            res.ok = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (batch.size() == 0) begin
      res.pend = PENDING_W'(ev_count);
      batch.push_back(res);
    end
    foreach (batch[i]) awaited_results.push_back(batch[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_result_t want;
    if (!rst_ni) begin
      rd_idx   = 0;
      wr_idx   = 0;
      ev_count = 0;
      tbl_used = 0;
      errors   = 0;
      awaited_results.delete();
      err_count_o <= 0;
      awaiting_o  <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h last %0b",
                   $time, m_tdata_i, m_tuser_i, m_tlast_i);
        end else begin
          want = awaited_results.pop_front();
          check_field("ok", want.ok, m_tuser_i[0]);
          check_field("delivered", want.dlv, m_tuser_i[1]);
          check_field("target_handler", want.tgt, m_tdata_i[7:0]);
          check_field("out_kind", want.kind, m_tdata_i[15:8]);
          check_field("out_payload", want.pay, m_tdata_i[47:16]);
          check_field("pending", want.pend, m_tdata_i[53:48]);
          check_field("tdata pad", 64'd0, m_tdata_i[55:54]);
          check_field("last_of_run", want.last, m_tlast_i);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_request(s_tuser_i, s_tdata_i[7:0], s_tdata_i[15:8], s_tdata_i[47:16]);
      end
      err_count_o <= errors;
      awaiting_o  <= awaited_results.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Testbench top: clock, reset, request stimulus, result back-pressure and the verdict.
`timescale 1ns / 1ps

module testbench;
  import eqsd_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_RESERVED_A = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RESERVED_B = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RESERVED_C = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 90;
  localparam int unsigned SETTLE      = 40;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [OPCODE_W-1:0]  s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  int unsigned err_count;
  int unsigned awaiting;
  int unsigned cycle_cnt = 0;
  int unsigned hold_seq = 0;
  bit          no_idle = 1'b0;

  logic [KIND_W-1:0] kind_pool [4] = '{8'h5A, 8'hFF, 8'h00, 8'h3C};
  logic [HID_W-1:0]  hid_pool  [4] = '{8'h01, 8'h80, 8'hFF, 8'h00};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  event_queue_subscription_dispatcher i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  eqsd_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tlast_i   (m_axis_tlast),
    .err_count_o (err_count),
    .awaiting_o  (awaiting)
  );

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // result side: random back-pressure, a long hold on request
  initial begin
    int unsigned seen;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen) begin
        seen = hold_seq;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 33);
    end
  end

  task automatic send_req(logic [OPCODE_W-1:0] op, logic [KIND_W-1:0] kind,
                          logic [HID_W-1:0] hid, logic [IN_PAY_W-1:0] pay);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {pay, hid, kind};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [OPCODE_W-1:0] op;
    logic [KIND_W-1:0]   kind;
    logic [HID_W-1:0]    hid;
    logic [IN_PAY_W-1:0] pay;
    int unsigned         roll;
    int unsigned         pub_w;
    int unsigned         proc_w;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(OP_PROCESS, 8'h00, 8'h00, 32'h0);
    send_req(OP_UNSUBSCRIBE, 8'h5A, 8'h01, 32'h0);
    send_req(OP_ENABLE, 8'h5A, 8'h01, 32'h0);
    send_req(OP_SUBSCRIBE, 8'h5A, 8'h01, 32'h0);
    send_req(OP_SUBSCRIBE, 8'h5A, 8'h00, 32'h0);
    send_req(OP_SUBSCRIBE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_req(OP_SUBSCRIBE, 8'h5A, 8'h80, 32'h0);
    send_req(OP_SUBSCRIBE, 8'h5A, 8'h01, 32'h0);
    send_req(OP_PUBLISH, 8'h5A, 8'hFF, 32'h0000_0000);
    send_req(OP_PUBLISH, 8'hFF, 8'h00, 32'hFFFF_FFFF);
    send_req(OP_PUBLISH, 8'h00, 8'h00, 32'hA5A5_5A5A);
    send_req(OP_PROCESS, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_req(OP_PROCESS, 8'h00, 8'h00, 32'h0);
    send_req(OP_PROCESS, 8'h00, 8'h00, 32'h0);
    send_req(OP_UNSUBSCRIBE, 8'h5A, 8'h80, 32'h0);
    send_req(OP_PUBLISH, 8'h5A, 8'h00, 32'h1234_5678);
    send_req(OP_PROCESS, 8'h00, 8'h00, 32'h0);
    send_req(OP_ENABLE, 8'h5A, 8'h80, 32'h0);
    send_req(OP_RESERVED_A, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_req(OP_RESERVED_B, 8'h5A, 8'h01, 32'h0);
    send_req(OP_RESERVED_C, 8'h00, 8'h00, 32'hDEAD_BEEF);
    send_req(OP_UNSUBSCRIBE, 8'hFF, 8'hFF, 32'h0);
    send_req(OP_PUBLISH, 8'hFF, 8'h01, 32'h8000_0001);
    send_req(OP_PROCESS, 8'h00, 8'h00, 32'h0);
    drain_results();

    for (int blk = 0; blk < 10; blk++) begin
      no_idle = (blk == 4 || blk == 5);
      if (blk == 1) hold_seq++;
      if (blk == 6) drain_results();
      case (blk % 4)
        0: begin
          pub_w  = 24;
          proc_w = 24;
        end
        3: begin
          pub_w  = 5;
          proc_w = 85;
        end
        default: begin
          pub_w  = 85;
          proc_w = 5;
        end
      endcase
      for (int j = 0; j < 16; j++) begin
        roll = $urandom_range(99);
        if (roll < pub_w) begin
          op = OP_PUBLISH;
        end else if (roll < pub_w + proc_w) begin
          op = OP_PROCESS;
        end else begin
          roll = $urandom_range(99);
          if (roll < 45) op = OP_SUBSCRIBE;
          else if (roll < 65) op = OP_UNSUBSCRIBE;
          else if (roll < 85) op = OP_ENABLE;
          else op = OPCODE_W'($urandom_range(OP_RESERVED_C, OP_RESERVED_A));
        end
        kind = ($urandom_range(99) < 75) ? kind_pool[$urandom_range(3)] : KIND_W'($urandom);
        hid  = ($urandom_range(99) < 60) ? hid_pool[$urandom_range(3)] : HID_W'($urandom);
        roll = $urandom_range(99);
        pay  = (roll < 5) ? '0 : (roll < 10) ? '1 : IN_PAY_W'($urandom);
        if (!no_idle && $urandom_range(99) < 33) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(3, 1)) @(posedge clk_i);
        end
        send_req(op, kind, hid, pay);
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (err_count == 0 && awaiting == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
